[src/pht_pkg.sv]
// shared constants and entry type for the probed hash table
package pht_pkg;

  localparam int unsigned TableSlotsDef = 4096;
  localparam int unsigned ProbesDef     = 8;
  localparam int unsigned TableCountDef = 2;

  localparam int unsigned KeyW   = 32;
  localparam int unsigned LockW  = 32;
  localparam int unsigned ValueW = 16;

  typedef struct packed {
    logic [LockW-1:0]         lock;
    logic signed [ValueW-1:0] value;
  } entry_t;

endpackage

[src/probed_hash_table_insert_lookup.sv]
// probed hash table with insert and lookup over a single entry memory
//
// Each table holds TABLE_SLOTS + PROBES entries of lock and value in one shared memory
// of TABLE_COUNT * (TABLE_SLOTS + PROBES) words. An item is one transfer on the input
// channel and yields exactly one result transfer. The home slot is the low bits of
// hash_key, and up to PROBES consecutive entries are read from there, one per cycle on
// the memory's read port, stopping at the first empty entry (insert) or matching lock
// (lookup). An item with a zero lock or an absent table makes no memory access and goes
// straight to its result, and the next item is taken as soon as the result sits in the output
// register. After reset the block clears the memory, one entry per cycle, over all
// TABLE_COUNT * (TABLE_SLOTS + PROBES) entries (8208 at the default sizes) and holds
// in_stall_o high during that sweep.
module probed_hash_table_insert_lookup #(
  parameter int unsigned TABLE_SLOTS = pht_pkg::TableSlotsDef,
  parameter int unsigned PROBES      = pht_pkg::ProbesDef,
  parameter int unsigned TABLE_COUNT = pht_pkg::TableCountDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              mode_i,
  input  logic                              table_select_i,
  input  logic [pht_pkg::KeyW-1:0]          hash_key_i,
  input  logic [pht_pkg::LockW-1:0]         check_lock_i,
  input  logic signed [pht_pkg::ValueW-1:0] entry_value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              success_o,
  output logic signed [pht_pkg::ValueW-1:0] found_value_o
);
  import pht_pkg::*;

  localparam int unsigned Span  = TABLE_SLOTS + PROBES;
  localparam int unsigned Depth = TABLE_COUNT * Span;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned SW    = $clog2(TABLE_SLOTS);
  localparam int unsigned PW    = (PROBES > 1) ? $clog2(PROBES) : 1;

  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_SEARCH = 2'd2;
  localparam logic [1:0] ST_DONE   = 2'd3;

  logic [1:0]  state_q, state_d;
  logic [AW-1:0] clr_addr_q, clr_addr_d;
  logic [AW-1:0] raddr_q, raddr_d;
  logic [AW-1:0] chk_addr_q, chk_addr_d;
  logic [PW:0]   issue_cnt_q, issue_cnt_d;
  logic [PW-1:0] chk_cnt_q, chk_cnt_d;
  logic          rvalid_q, rvalid_d;

  logic                    mode_q, mode_d;
  logic [LockW-1:0]        lock_q, lock_d;
  logic signed [ValueW-1:0] value_q, value_d;
  logic                    res_success_q, res_success_d;
  logic signed [ValueW-1:0] res_value_q, res_value_d;

  logic                    out_valid_q, out_valid_d;
  logic                    success_q, success_d;
  logic signed [ValueW-1:0] found_value_q, found_value_d;

  entry_t        mem_q [Depth];
  entry_t        rdata_q;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic          mem_re;

  logic          in_xfer;
  logic          skip;
  logic [AW-1:0] start_addr;
  logic          hit;
  logic          out_free;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign skip = ({31'd0, table_select_i} >= 32'(TABLE_COUNT)) || (check_lock_i == '0);
  assign start_addr = (table_select_i ? AW'(Span) : AW'(0)) + AW'(hash_key_i[SW-1:0]);

  assign mem_re = (state_q == ST_SEARCH) && (issue_cnt_q < (PW+1)'(PROBES));
  assign hit    = mode_q ? (rdata_q.lock == '0) : (rdata_q.lock == lock_q);

  always_comb begin
    state_d       = state_q;
    clr_addr_d    = clr_addr_q;
    raddr_d       = raddr_q;
    chk_addr_d    = chk_addr_q;
    issue_cnt_d   = issue_cnt_q;
    chk_cnt_d     = chk_cnt_q;
    rvalid_d      = mem_re;
    mode_d        = mode_q;
    lock_d        = lock_q;
    value_d       = value_q;
    res_success_d = res_success_q;
    res_value_d   = res_value_q;
    out_valid_d   = out_valid_q && out_stall_i;
    success_d     = success_q;
    found_value_d = found_value_q;
    mem_we        = 1'b0;
    mem_waddr     = clr_addr_q;
    mem_wdata     = '0;

    if (mem_re) begin
      raddr_d     = raddr_q + AW'(1);
      chk_addr_d  = raddr_q;
      issue_cnt_d = issue_cnt_q + (PW+1)'(1);
    end

    unique case (state_q)
      ST_CLEAR: begin
        mem_we     = 1'b1;
        clr_addr_d = clr_addr_q + AW'(1);
        if (clr_addr_q == AW'(Depth - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          mode_d        = mode_i;
          lock_d        = check_lock_i;
          value_d       = entry_value_i;
          raddr_d       = start_addr;
          issue_cnt_d   = '0;
          chk_cnt_d     = '0;
          res_success_d = 1'b0;
          res_value_d   = '0;
          state_d       = skip ? ST_DONE : ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (rvalid_q) begin
          chk_cnt_d = chk_cnt_q + PW'(1);
          if (hit) begin
            res_success_d = 1'b1;
            res_value_d   = mode_q ? '0 : rdata_q.value;
            state_d       = ST_DONE;
            if (mode_q) begin
              mem_we          = 1'b1;
              mem_waddr       = chk_addr_q;
              mem_wdata.lock  = lock_q;
              mem_wdata.value = value_q;
            end
          end else if (chk_cnt_q == PW'(PROBES - 1)) begin
            state_d = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d   = 1'b1;
          success_d     = res_success_q;
          found_value_d = res_value_q;
          state_d       = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_addr_q  <= '0;
      issue_cnt_q <= '0;
      chk_cnt_q   <= '0;
      rvalid_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_addr_q  <= clr_addr_d;
      issue_cnt_q <= issue_cnt_d;
      chk_cnt_q   <= chk_cnt_d;
      rvalid_q    <= rvalid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    raddr_q       <= raddr_d;
    chk_addr_q    <= chk_addr_d;
    mode_q        <= mode_d;
    lock_q        <= lock_d;
    value_q       <= value_d;
    res_success_q <= res_success_d;
    res_value_q   <= res_value_d;
    success_q     <= success_d;
    found_value_q <= found_value_d;
  end

  // entry memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[raddr_q];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign success_o     = success_q;
  assign found_value_o = found_value_q;

  a_write_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == ST_CLEAR) || (state_q == ST_SEARCH && mode_q))
    else $error("entry write outside clear sweep or insert");

  a_no_zero_lock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && state_q == ST_SEARCH) |-> (mem_wdata.lock != '0))
    else $error("insert writes an empty lock");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !success_o) |-> (found_value_o == '0))
    else $error("nonzero value without success");

  a_read_only_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rvalid_q |-> $past(state_q) == ST_SEARCH)
    else $error("read data outside a search");

endmodule

[dv/probed_hash_table_insert_lookup_tb.sv]
// testbench for the probed hash table: directed and random insert/lookup traffic against a predictor
`timescale 1ns / 100ps

module probed_hash_table_insert_lookup_tb;
  import pht_pkg::*;

  localparam int unsigned TableSlots = TableSlotsDef;
  localparam int unsigned Probes     = ProbesDef;
  localparam int unsigned TableCount = TableCountDef;
  localparam int unsigned Span       = TableSlots + Probes;
  localparam logic [KeyW-1:0] HomeMask = TableSlots - 1;

  localparam time ClkPeriod  = 10;
  localparam int  MaxReports = 40;

  localparam bit ModeLookup = 1'b0;
  localparam bit ModeInsert = 1'b1;

  localparam int StallNone   = 0;
  localparam int StallRandom = 1;
  localparam int StallHold   = 2;

  typedef struct {
    bit                       hit;
    logic signed [ValueW-1:0] value;
  } outcome_t;

  typedef struct {
    bit              tsel;
    logic [KeyW-1:0]  key;
    logic [LockW-1:0] lock;
  } key_lock_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic                     mode_i;
  logic                     table_select_i;
  logic [KeyW-1:0]          hash_key_i;
  logic [LockW-1:0]         check_lock_i;
  logic signed [ValueW-1:0] entry_value_i;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic                     success_o;
  logic signed [ValueW-1:0] found_value_o;

  entry_t    table_store [TableCount][Span];
  outcome_t  pending_q [$];
  key_lock_t inserted_q [$];
  int unsigned home_pool [$];

  int error_count = 0;
  int burst_left  = 0;
  int stall_left  = 0;
  int stall_kind  = StallNone;

  probed_hash_table_insert_lookup #(
    .TABLE_SLOTS (TableSlots),
    .PROBES      (Probes),
    .TABLE_COUNT (TableCount)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mode_i         (mode_i),
    .table_select_i (table_select_i),
    .hash_key_i     (hash_key_i),
    .check_lock_i   (check_lock_i),
    .entry_value_i  (entry_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .success_o      (success_o),
    .found_value_o  (found_value_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  function automatic void clear_store();
    int unsigned t;
    int unsigned s;
    for (t = 0; t < TableCount; t++) begin
      for (s = 0; s < Span; s++) begin
        table_store[t][s] = '0;
      end
    end
  endfunction

  function automatic outcome_t probe_table(bit m, bit t, logic [KeyW-1:0] k,
                                           logic [LockW-1:0] l,
                                           logic signed [ValueW-1:0] v);
    outcome_t    res;
    int unsigned home;
    int unsigned idx;
    int unsigned i;
    bit          done;
    res.hit   = 1'b0;
    res.value = '0;
    done      = 1'b0;
    home      = k & HomeMask;
    if (t < TableCount && l != '0) begin
      for (i = 0; i < Probes && !done; i++) begin
        idx = home + i;
        if (idx < Span) begin
          if (m == ModeInsert && table_store[t][idx].lock == '0) begin
            table_store[t][idx].lock  = l;
            table_store[t][idx].value = v;
            res.hit = 1'b1;
            done    = 1'b1;
          end else if (m == ModeLookup && table_store[t][idx].lock == l) begin
            res.hit   = 1'b1;
            res.value = table_store[t][idx].value;
            done      = 1'b1;
          end
        end
      end
    end
    return res;
  endfunction

  task automatic send_item(bit m, bit t, logic [KeyW-1:0] k, logic [LockW-1:0] l,
                           logic signed [ValueW-1:0] v);
    outcome_t res;
    @(negedge clk_i);
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    in_valid_i     <= 1'b1;
    mode_i         <= m;
    table_select_i <= t;
    hash_key_i     <= k;
    check_lock_i   <= l;
    entry_value_i  <= v;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    res = probe_table(m, t, k, l, v);
    pending_q.push_back(res);
    burst_left--;
  endtask

  task automatic run_traffic(int items);
    int          n;
    int unsigned pick;
    int unsigned home;
    logic [31:0] rnd_key;
    logic [31:0] rnd_lock;
    logic [31:0] rnd_val;
    key_lock_t   ent;
    bit          m;
    bit          t;
    logic [KeyW-1:0]  k;
    logic [LockW-1:0] l;
    for (n = 0; n < items; n++) begin
      rnd_key  = $urandom;
      rnd_lock = $urandom;
      rnd_val  = $urandom;
      home     = home_pool[$urandom_range(0, home_pool.size() - 1)];
      pick     = $urandom_range(0, 99);
      if (pick < 45 || inserted_q.size() == 0) begin
        m = ModeInsert;
        t = 1'($urandom_range(0, 1));
        k = (rnd_key & ~HomeMask) | home;
        l = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : rnd_lock;
        inserted_q.push_back('{t, k, l});
      end else if (pick < 90) begin
        ent = inserted_q[$urandom_range(0, inserted_q.size() - 1)];
        m   = ModeLookup;
        t   = ent.tsel ^ ($urandom_range(0, 5) == 0);
        k   = (rnd_key & ~HomeMask) | (ent.key & HomeMask);
        l   = ent.lock;
      end else begin
        m = 1'($urandom_range(0, 1));
        t = 1'($urandom_range(0, 1));
        k = rnd_key;
        l = $urandom_range(0, 1) ? '0 : rnd_lock;
      end
      send_item(m, t, k, l, rnd_val[ValueW-1:0]);
    end
  endtask

  task automatic test_empty_and_zero_lock();
    send_item(ModeLookup, 1'b0, 32'h0000_0abc, 32'h0000_0001, 16'sh0000);
    send_item(ModeLookup, 1'b1, 32'hdead_b000, 32'h0000_0000, 16'sh0000);
    send_item(ModeInsert, 1'b0, 32'h0000_0abc, 32'h0000_0000, 16'sh0063);
    send_item(ModeLookup, 1'b0, 32'h0000_0abc, 32'h0000_0000, 16'sh0000);
  endtask

  task automatic test_extreme_entries();
    send_item(ModeInsert, 1'b0, 32'hffff_ffff, 32'hffff_ffff, 16'sh7fff);
    send_item(ModeInsert, 1'b1, 32'hffff_f000, 32'h8000_0001, 16'sh8000);
    send_item(ModeLookup, 1'b0, 32'hffff_ffff, 32'hffff_ffff, 16'sh8000);
    send_item(ModeLookup, 1'b1, 32'h0000_0000, 32'h8000_0001, 16'sh7fff);
    send_item(ModeLookup, 1'b0, 32'h0000_0000, 32'h8000_0001, 16'sh0000);
    send_item(ModeLookup, 1'b1, 32'h0000_0001, 32'h8000_0001, 16'sh0000);
  endtask

  task automatic test_duplicate_lock();
    send_item(ModeInsert, 1'b1, 32'h0000_1000, 32'h8000_0001, 16'sh0005);
    send_item(ModeLookup, 1'b1, 32'h7000_0000, 32'h8000_0001, 16'sh0000);
    send_item(ModeLookup, 1'b1, 32'h7000_0001, 32'h8000_0001, 16'sh0000);
  endtask

  task automatic test_full_window_at_top();
    int i;
    for (i = 0; i < 8; i++) begin
      send_item(ModeInsert, 1'b0, 32'h5a5a_5fff ^ (i << 20), 32'h0000_0100 + i,
                16'sh1000 + 16'(i));
    end
    send_item(ModeLookup, 1'b0, 32'h0000_0fff, 32'h0000_0106, 16'sh0000);
    send_item(ModeLookup, 1'b0, 32'h0000_0fff, 32'h0000_0107, 16'sh0000);
  endtask

  task automatic test_clustered_traffic();
    int          i;
    int unsigned base;
    home_pool = {};
    home_pool.push_back(TableSlots - 1);
    home_pool.push_back(TableSlots - 3);
    home_pool.push_back(0);
    home_pool.push_back(1);
    for (i = 0; i < 4; i++) begin
      base = $urandom_range(0, TableSlots - 4);
      home_pool.push_back(base);
      home_pool.push_back(base + 3);
    end
    run_traffic(600);
  endtask

  task automatic test_spread_traffic();
    int i;
    home_pool = {};
    for (i = 0; i < 256; i++) begin
      home_pool.push_back($urandom_range(0, TableSlots - 1));
    end
    run_traffic(450);
  endtask

  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_kind = $urandom_range(StallNone, StallHold);
      stall_left = $urandom_range(4, 40);
    end
    stall_left--;
    case (stall_kind)
      StallNone: begin
        out_stall_i <= 1'b0;
      end
      StallRandom: begin
        out_stall_i <= 1'($urandom_range(0, 1));
      end
      default: begin
        out_stall_i <= (stall_left < 6);
      end
    endcase
  end

  always @(posedge clk_i) begin : check_result
    outcome_t exp_res;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_q.size() == 0) begin
        error_count++;
        if (error_count <= MaxReports) begin
          $display("%0t: unexpected result transfer, expected none, got success %0b value %0d",
                   $time, success_o, found_value_o);
        end
      end else begin
        exp_res = pending_q.pop_front();
        if (success_o !== exp_res.hit) begin
          error_count++;
          if (error_count <= MaxReports) begin
            $display("%0t: success mismatch, expected %0b, got %0b",
                     $time, exp_res.hit, success_o);
          end
        end
        if (found_value_o !== exp_res.value) begin
          error_count++;
          if (error_count <= MaxReports) begin
            $display("%0t: found_value mismatch, expected %0d, got %0d",
                     $time, exp_res.value, found_value_o);
          end
        end
      end
    end
  end

  initial begin
    #(5_000_000);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    mode_i         = ModeLookup;
    table_select_i = 1'b0;
    hash_key_i     = '0;
    check_lock_i   = '0;
    entry_value_i  = '0;
    clear_store();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_and_zero_lock();
    test_extreme_entries();
    test_duplicate_lock();
    test_full_window_at_top();
    test_clustered_traffic();
    test_spread_traffic();

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (Probes + 20) @(posedge clk_i);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[files.f]
src/pht_pkg.sv
src/probed_hash_table_insert_lookup.sv
dv/probed_hash_table_insert_lookup_tb.sv
